// ===== sv/dfs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dfs_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_STARTUP  = 3'd1,
    MODE_SHUTDOWN = 3'd2,
    MODE_GO       = 3'd3,
    MODE_RAMP     = 3'd4,
    MODE_STOP     = 3'd5
  } play_mode_t;

  localparam logic       CMD_TICK = 1'b0;
  localparam logic       CMD_SET_MODE = 1'b1;

  localparam logic [31:0] ZERO_LEVEL_RESET = 32'h4000_0000;
  localparam logic [31:0] RAMP_STEP = 32'h0000_8000;
  localparam logic [31:0] SLEW_STEP2 = 32'h0001_0000;
  localparam logic [31:0] STARTUP_LOW = 32'h0001_0000;
  localparam logic [31:0] STARTUP_HIGH = 32'hFFFF_0000;
  localparam logic [31:0] SHUTDOWN_LOW = 32'h7FFF_0000;
  localparam logic [31:0] SHUTDOWN_HIGH = 32'h8001_0000;
  localparam logic [31:0] SHUTDOWN_TARGET2 = 32'h8000_0000;
  localparam logic [31:0] SHUTDOWN_DONE = 32'h4000_0000;

  typedef struct packed {
    logic        mode;
    logic [2:0]  new_play_mode;
    logic [31:0] head_sample;
  } dfs_in_t;

  typedef struct packed {
    logic [31:0] dac_word;
    logic        sample_consumed;
    logic [2:0]  current_mode;
    logic [31:0] tick_count;
  } dfs_out_t;

endpackage

`default_nettype wire

// ===== sv/dfs_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface dfs_in_if
  import dfs_pkg::*;
();
  logic    valid;
  logic    ready;
  dfs_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dfs_out_if
  import dfs_pkg::*;
();
  logic     valid;
  logic     ready;
  dfs_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/dac_feed_soft_ramp_sequencer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// A tick transaction's result is registered and shows in the cycle after it is accepted.
// Throughput: one transaction per cycle; the single output register is refilled in
// the same cycle it is drained, so ready drops only while a result waits unread.
// Command transactions update the play mode and produce no result.
// Reset (rst_n low, synchronous) loads zero_level and all held words with
// 0x40000000, selects the left channel, enters idle and clears the tick count.
module dac_feed_soft_ramp_sequencer_top
  import dfs_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  dfs_in_if.sink            in_if,
  dfs_out_if.source         out_if,
  input  wire logic         cfg_we,
  input  wire logic [31:0]  cfg_wdata
);

  logic [31:0] zero_level_r;
  logic [31:0] next_word_r, next_word_nxt;
  logic [31:0] held_left_r, held_left_nxt;
  logic [31:0] held_right_r, held_right_nxt;
  logic        chan_sel_r, chan_sel_nxt;
  play_mode_t  play_state_r, play_state_nxt;
  logic [31:0] served_r, served_nxt;
  logic        consumed;
  logic        out_valid_r;
  dfs_out_t    out_data_r;

  logic        accept;
  logic        is_cmd;
  logic [31:0] head;
  logic [31:0] dbl;
  logic [31:0] slew_target;
  logic [31:0] slewed;

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign accept = in_if.valid && in_if.ready;
  assign is_cmd = (in_if.data.mode == CMD_SET_MODE);
  assign head = in_if.data.head_sample;
  assign dbl = {next_word_r[30:0], 1'b0};
  assign slew_target = (play_state_r == MODE_RAMP) ? head : zero_level_r;
  assign slewed = (next_word_r > slew_target) ? next_word_r - RAMP_STEP
                                              : next_word_r + RAMP_STEP;

  always_comb begin
    next_word_nxt = next_word_r;
    held_left_nxt = held_left_r;
    held_right_nxt = held_right_r;
    chan_sel_nxt = chan_sel_r;
    consumed = 1'b0;
    unique case (play_state_r)
      MODE_STARTUP: begin
        if (next_word_r != 32'd0) begin
          if (dbl <= STARTUP_LOW || dbl >= STARTUP_HIGH) begin
            next_word_nxt = 32'd0;
          end else begin
            next_word_nxt = (dbl + SLEW_STEP2) >> 1;
          end
        end
      end
      MODE_SHUTDOWN: begin
        if (next_word_r != SHUTDOWN_DONE) begin
          if (dbl <= SHUTDOWN_HIGH && dbl >= SHUTDOWN_LOW) begin
            next_word_nxt = SHUTDOWN_TARGET2 >> 1;
          end else begin
            next_word_nxt = (dbl - SLEW_STEP2) >> 1;
          end
        end
      end
      MODE_GO: begin
        next_word_nxt = head;
        if (!chan_sel_r) begin
          held_left_nxt = head;
        end else begin
          held_right_nxt = head;
        end
        chan_sel_nxt = !chan_sel_r;
        consumed = 1'b1;
      end
      MODE_RAMP, MODE_STOP: begin
        next_word_nxt = slewed;
      end
      default: begin
        next_word_nxt = chan_sel_r ? held_right_r : held_left_r;
        chan_sel_nxt = !chan_sel_r;
      end
    endcase
  end

  always_comb begin
    play_state_nxt = play_state_r;
    if (is_cmd) begin
      unique case (play_mode_t'(in_if.data.new_play_mode))
        MODE_IDLE, MODE_STARTUP, MODE_SHUTDOWN, MODE_GO, MODE_RAMP, MODE_STOP: begin
          play_state_nxt = play_mode_t'(in_if.data.new_play_mode);
        end
        default: begin
          play_state_nxt = MODE_IDLE;
        end
      endcase
    end else if (play_state_r == MODE_RAMP &&
                 slewed[31:15] == head[31:15]) begin
      play_state_nxt = MODE_GO;
    end else if (play_state_r == MODE_STOP &&
                 slewed[31:15] == zero_level_r[31:15]) begin
      play_state_nxt = MODE_IDLE;
    end
  end

  assign served_nxt = served_r + 32'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_level_r <= ZERO_LEVEL_RESET;
      next_word_r <= ZERO_LEVEL_RESET;
      held_left_r <= ZERO_LEVEL_RESET;
      held_right_r <= ZERO_LEVEL_RESET;
      chan_sel_r <= 1'b0;
      play_state_r <= MODE_IDLE;
      served_r <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        zero_level_r <= cfg_wdata;
      end
      if (accept) begin
        play_state_r <= play_state_nxt;
        if (!is_cmd) begin
          next_word_r <= next_word_nxt;
          held_left_r <= held_left_nxt;
          held_right_r <= held_right_nxt;
          chan_sel_r <= chan_sel_nxt;
          served_r <= served_nxt;
        end
      end
      if (accept && !is_cmd) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !is_cmd) begin
      out_data_r.dac_word <= next_word_r;
      out_data_r.sample_consumed <= consumed;
      out_data_r.current_mode <= play_state_nxt;
      out_data_r.tick_count <= served_nxt;
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.data = out_data_r;

`ifndef SYNTHESIS
  a_consumed_in_go: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.sample_consumed) |->
      (out_data_r.current_mode == MODE_GO))
    else $error("sample consumed outside go mode");

  a_cmd_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_cmd && !out_valid_r) |=> !out_valid_r)
    else $error("command transaction produced a result");

  a_go_toggles_channel: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !is_cmd && play_state_r == MODE_GO) |=>
      (chan_sel_r != $past(chan_sel_r)))
    else $error("go tick did not alternate channel");

  a_tick_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !is_cmd) |=> (out_data_r.tick_count == served_r))
    else $error("tick count out of step with served ticks");
`endif

endmodule

`default_nettype wire
